FILE: sv/bitmap_page_allocator_assert.svh
// Assertion macros for the bitmap page allocator.
// Uses the clk and rst names of the module that includes it.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(name, prop, msg)
`define BPA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: sv/bpa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, result codes and controller/datapath types of the page allocator.
// No dependencies.
package bpa_pkg;

  localparam int DEF_POOL_WORDS = 2048;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam logic [31:0] BASE_RESET = 32'h3000_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [2:0] bpa_status_t;

  localparam bpa_status_t ST_DIRECT  = 3'd0;
  localparam bpa_status_t ST_ALLOC   = 3'd1;
  localparam bpa_status_t ST_FREED   = 3'd2;
  localparam bpa_status_t ST_FULL    = 3'd3;
  localparam bpa_status_t ST_OUTSIDE = 3'd4;

  typedef struct packed {
    logic        clear_step;
    logic        capture;
    logic        rd_l1;
    logic        rd_l0;
    logic        rd_free;
    logic        commit_alloc;
    logic        commit_free;
    logic        emit;
    bpa_status_t status;
  } bpa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic op;
    logic direct;
    logic l2_full;
    logic outside;
    logic overflow;
    logic out_free;
  } bpa_sts_t;

endpackage

FILE: sv/bpa_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the page allocator.
// No dependencies.
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] address;
  logic [31:0] length;

  modport source(output valid, op, address, length, input ready);
  modport sink(input valid, op, address, length, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  status;

  modport source(output valid, result_address, status, input ready);
  modport sink(input valid, result_address, status, output ready);
endinterface

FILE: sv/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// Allocate: decode, summary read, map read, update; the result is registered at the update.
// Free: decode, map read, update; direct map, pool full at decode and free outside pool end at decode.
// Allocate reads the summary, then the page map; no new request is taken before the last ends.
// After reset the page map is cleared one word per cycle, with no item taken.
// Configuration writes are taken at any time and pool_base resets to 0x30000000.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int POOL_WORDS = DEF_POOL_WORDS,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  bpa_req_if.sink     req,
  bpa_rsp_if.source   rsp
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .POOL_WORDS (POOL_WORDS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .op             (req.op),
    .address        (req.address),
    .length         (req.length),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .result_address (rsp.result_address),
    .status         (rsp.status)
  );

endmodule

FILE: sv/bpa_datapath.sv
`timescale 1ns / 1ps
// Datapath of the page allocator: page map, summary memory, full-word flags and result register.
// Depends on bpa_pkg.
module bpa_datapath import bpa_pkg::*; #(
  parameter int POOL_WORDS = DEF_POOL_WORDS,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [31:0] length,
  input  bpa_cmd_t    cmd,
  output bpa_sts_t    sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] result_address,
  output logic [2:0]  status
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int POOL_PAGES = POOL_WORDS * 32;
  localparam int L1_WORDS   = (POOL_WORDS + 31) / 32;
  localparam int W_BITS     = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int L1_BITS    = (L1_WORDS > 1) ? $clog2(L1_WORDS) : 1;
  localparam int WI_BITS    = L1_BITS + 5;
  localparam int PI_BITS    = WI_BITS + 5;
  localparam int OFF_W      = PI_BITS + PAGE_SHIFT;
  localparam int SUM_W      = ((OFF_W > 32) ? OFF_W : 32) + 1;
  localparam int IDX_W      = 32 - PAGE_SHIFT;
  localparam int PAD_REM    = POOL_WORDS % 32;
  localparam logic [31:0] PAD_MASK = (PAD_REM == 0) ? 32'h0 :
                                     ~((32'h1 << PAD_REM) - 32'h1);

  function automatic logic [4:0] ffz32(input logic [31:0] w);
    logic [4:0] r;
    r = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) r = 5'(i);
    end
    return r;
  endfunction

  logic [31:0]         pool_base;
  logic                op_q;
  logic [31:0]         addr_q;
  logic [31:0]         len_q;
  logic [L1_BITS-1:0]  l1_q;
  logic [WI_BITS-1:0]  wi;
  logic [WI_BITS-1:0]  wi_next;
  logic [4:0]          bit_q;
  logic [W_BITS-1:0]   clr_cnt;
  logic [L1_WORDS-1:0] l2;
  logic [L1_BITS-1:0]  l2_ffz;

  logic [31:0] m_mem [POOL_WORDS];
  logic [31:0] m_rdata;
  logic        m_we;
  logic        m_re;
  logic [W_BITS-1:0] m_waddr;
  logic [W_BITS-1:0] m_raddr;
  logic [31:0] m_wdata;

  logic [31:0] s_mem [L1_WORDS];
  logic [31:0] s_rdata;
  logic        s_we;
  logic        s_re;
  logic [L1_BITS-1:0] s_waddr;
  logic [L1_BITS-1:0] s_raddr;
  logic [31:0] s_wdata;

  logic [32:0]        end_sum;
  logic [31:0]        diff;
  logic [IDX_W-1:0]   fidx;
  logic [WI_BITS-1:0] free_wi;
  logic [L1_BITS-1:0] free_l1;
  logic [4:0]         s_ffz;
  logic [4:0]         m_ffz;
  logic [PI_BITS-1:0] page_idx;
  logic [OFF_W-1:0]   page_off;
  logic [SUM_W-1:0]   page_sum;
  logic [31:0]        m_set;
  logic [31:0]        m_clr;
  logic [31:0]        s_set;
  logic [31:0]        s_clr;
  logic               word_full;
  logic               clr_in_l1;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= BASE_RESET;
    end else if (cfg_write) begin
      pool_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      addr_q <= address;
      len_q  <= length;
    end
    if (cmd.rd_l1) begin
      l1_q <= l2_ffz;
    end
    if (cmd.rd_free) begin
      l1_q  <= free_l1;
      bit_q <= fidx[4:0];
    end
    if (cmd.rd_l0 || cmd.rd_free) begin
      wi <= wi_next;
    end
  end

  assign end_sum  = {1'b0, addr_q} + {1'b0, len_q};
  assign diff     = addr_q - pool_base;
  assign fidx     = diff[31:PAGE_SHIFT];
  assign free_wi  = WI_BITS'(fidx >> 5);
  assign free_l1  = L1_BITS'(fidx >> 10);
  assign s_ffz    = ffz32(s_rdata);
  assign m_ffz    = ffz32(m_rdata);
  assign wi_next  = cmd.rd_l0 ? {l1_q, s_ffz} : free_wi;

  assign page_idx = {wi, m_ffz};
  assign page_off = {page_idx, {PAGE_SHIFT{1'b0}}};
  assign page_sum = SUM_W'(pool_base) + SUM_W'(page_off);

  assign m_set     = m_rdata | (32'h1 << m_ffz);
  assign m_clr     = m_rdata & ~(32'h1 << bit_q);
  assign s_set     = s_rdata | (32'h1 << wi[4:0]);
  assign s_clr     = s_rdata & ~(32'h1 << wi[4:0]);
  assign word_full = &m_set;

  always_comb begin
    l2_ffz = '0;
    for (int i = L1_WORDS - 1; i >= 0; i--) begin
      if (!l2[i]) l2_ffz = L1_BITS'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + W_BITS'(1);
    end
  end

  assign clr_in_l1 = {1'b0, clr_cnt} < (W_BITS + 1)'(L1_WORDS);

  assign m_we    = cmd.clear_step || cmd.commit_alloc || cmd.commit_free;
  assign m_waddr = cmd.clear_step ? clr_cnt : wi[W_BITS-1:0];
  assign m_wdata = cmd.clear_step ? 32'h0 : (cmd.commit_alloc ? m_set : m_clr);
  assign m_re    = cmd.rd_l0 || cmd.rd_free;
  assign m_raddr = wi_next[W_BITS-1:0];

  always_ff @(posedge clk) begin
    if (m_we) m_mem[m_waddr] <= m_wdata;
    if (m_re) m_rdata <= m_mem[m_raddr];
  end

  // Summary bit set means the map word is full; bits past the pool read as full.
  assign s_we    = (cmd.clear_step && clr_in_l1) || (cmd.commit_alloc && word_full) ||
                   cmd.commit_free;
  assign s_waddr = cmd.clear_step ? clr_cnt[L1_BITS-1:0] : l1_q;
  always_comb begin
    if (cmd.clear_step) begin
      s_wdata = (clr_cnt == W_BITS'(L1_WORDS - 1)) ? PAD_MASK : 32'h0;
    end else if (cmd.commit_alloc) begin
      s_wdata = s_set;
    end else begin
      s_wdata = s_clr;
    end
  end
  assign s_re    = cmd.rd_l1 || cmd.rd_free;
  assign s_raddr = cmd.rd_l1 ? l2_ffz : free_l1;

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_waddr] <= s_wdata;
    if (s_re) s_rdata <= s_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2 <= '0;
    end else if (cmd.commit_alloc && word_full && (&s_set)) begin
      l2[l1_q] <= 1'b1;
    end else if (cmd.commit_free) begin
      l2[l1_q] <= 1'b0;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.status;
      case (cmd.status)
        ST_DIRECT: result_address <= addr_q;
        ST_ALLOC:  result_address <= page_sum[31:0];
        default:   result_address <= 32'h0;
      endcase
    end
  end

  always_comb begin
    sts.clear_done = clr_cnt == W_BITS'(POOL_WORDS - 1);
    sts.op         = op_q;
    sts.direct     = end_sum <= {1'b0, pool_base};
    sts.l2_full    = &l2;
    sts.outside    = (addr_q < pool_base) || (33'(fidx) >= 33'(POOL_PAGES));
    sts.overflow   = |page_sum[SUM_W-1:32];
    sts.out_free   = out_free;
  end

endmodule

FILE: sv/bpa_controller.sv
`timescale 1ns / 1ps
// Controller state machine of the page allocator: clearing pass, request decode and the
// summary-then-map search sequence. Depends on bpa_pkg and the assertion macro header.
`include "bitmap_page_allocator_assert.svh"
module bpa_controller import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  bpa_sts_t sts,
  output bpa_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_L1    = 3'd3;
  localparam logic [2:0] S_L0    = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == OP_FREE) begin
          if (sts.outside) begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_OUTSIDE;
              state_next = S_IDLE;
            end
          end else begin
            cmd.rd_free = 1'b1;
            state_next  = S_FREE;
          end
        end else if (sts.direct || sts.l2_full) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.status = sts.direct ? ST_DIRECT : ST_FULL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.rd_l1  = 1'b1;
          state_next = S_L1;
        end
      end
      S_L1: begin
        cmd.rd_l0  = 1'b1;
        state_next = S_L0;
      end
      S_L0: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.status       = sts.overflow ? ST_FULL : ST_ALLOC;
          cmd.commit_alloc = !sts.overflow;
          state_next       = S_IDLE;
        end
      end
      S_FREE: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.status      = ST_FREED;
          cmd.commit_free = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BPA_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_CLEAR), "reset did not start clearing")
  `BPA_ASSERT(a_emit_room, cmd.emit |-> sts.out_free, "result written over a waiting item")
  `BPA_ASSERT(a_summary_read, cmd.rd_l1 |-> !sts.l2_full, "summary read with no free word")
  `BPA_ASSERT(a_commit_emits, (cmd.commit_alloc || cmd.commit_free) |-> cmd.emit, "map changed without a result")

endmodule
